[src/packet_reorder_window_defines.svh]
// assertion macros for the packet reorder window
// used by the top level; expects clk and rst_n in scope where expanded
`ifndef PACKET_REORDER_WINDOW_DEFINES_SVH
`define PACKET_REORDER_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PRW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define PRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRW_ASSERT_IMPL(label, ante, cons, msg)
`define PRW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/prw_pkg.sv]
// shared types and constants for the packet reorder window
// no dependencies
package prw_pkg;

    // fixed field widths
    localparam int SEQ_BITS     = 32;
    localparam int STATUS_BITS  = 3;
    localparam int TIMEOUT_BITS = 16;
    localparam int IDLE_BITS    = 16;
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd100;

    // register index decoded from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_IN_ORDER = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FLUSHED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_STALE    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BEYOND   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BUFFERED = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic cap;     // capture the input transaction
        logic arrive;  // resolve a packet arrival and load its result
        logic tick;    // apply a time tick
        logic rd;      // read the payload memory at the scan slot
        logic skip;    // step the scan past an empty slot
        logic emit;    // load a drained or flushed entry into the output
        logic flush;   // scan is a timeout flush
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_tick;    // captured transaction is a tick
        logic arr_drain;  // arrival releases and has buffered successors
        logic flush_go;   // tick reaches the timeout with packets held
        logic cur_valid;  // scan slot holds a packet
        logic emit_last;  // scanned entry is the final result
        logic out_free;   // output register can take a result
    } dp_sts_t;

endpackage

[src/prw_regs.sv]
// configuration register bank behind the apb port
// depends on prw_pkg
module prw_regs
    import prw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_BITS-1:0]   paddr,
    input  logic [PDATA_BITS-1:0]   pwdata,
    output logic [PDATA_BITS-1:0]   prdata,
    output logic                    pready,
    output logic [TIMEOUT_BITS-1:0] timeout
);

    logic [TIMEOUT_BITS-1:0] timeout_reg;
    logic [TIMEOUT_BITS-1:0] timeout_next;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

    // register write
    always_comb
    begin
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            timeout_next = pwdata[TIMEOUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // readback
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TIMEOUT)
        begin
            prdata = {{(PDATA_BITS-TIMEOUT_BITS){1'b0}}, timeout_reg};
        end
    end

    assign timeout = timeout_reg;

endmodule

[src/prw_ctrl.sv]
// controller state machine: capture, decide, scan read and scan emit
// depends on prw_pkg
module prw_ctrl
    import prw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       flush_reg;
    logic       flush_next;

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        cmd.flush  = flush_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_tick)
                begin
                    cmd.tick = 1'b1;
                    if (sts.flush_go)
                    begin
                        flush_next = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (sts.out_free)
                begin
                    cmd.arrive = 1'b1;
                    flush_next = 1'b0;
                    state_next = sts.arr_drain ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                if (sts.cur_valid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EMIT;
                end
                else if (flush_reg)
                begin
                    // gap in the flush range
                    cmd.skip = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

endmodule

[src/prw_datapath.sv]
// datapath: window state, payload memory, scan pointer and output register
// depends on prw_pkg
module prw_datapath
    import prw_pkg::*;
#(
    parameter int WINDOW       = 32,
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    input  logic [TIMEOUT_BITS-1:0] timeout,
    input  logic                    mode,
    input  logic [SEQ_BITS-1:0]     seq_num,
    input  logic [PAYLOAD_BITS-1:0] payload_tag,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SEQ_BITS-1:0]     out_seq,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic [STATUS_BITS-1:0]  status,
    output logic                    last
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // slot of num + 1, given the slot of num; the count wraps to zero
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
                                                   input logic [SEQ_BITS-1:0] num);
        logic [SLOT_W-1:0] r;
        if (num == '1)
        begin
            r = '0;
        end
        else if (slot == SLOT_W'(WINDOW - 1))
        begin
            r = '0;
        end
        else
        begin
            r = slot + 1'b1;
        end
        return r;
    endfunction

    // captured transaction
    logic                    mode_reg;
    logic [SEQ_BITS-1:0]     seq_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // window state
    logic [SEQ_BITS-1:0]     exp_reg,      exp_next;
    logic [SLOT_W-1:0]       exp_slot_reg, exp_slot_next;
    logic [WINDOW-1:0]       valid_reg,    valid_next;
    logic [CNT_W-1:0]        held_reg,     held_next;
    logic [IDLE_BITS-1:0]    idle_reg,     idle_next;
    logic [SEQ_BITS-1:0]     ptr_reg,      ptr_next;
    logic [SLOT_W-1:0]       ptr_slot_reg, ptr_slot_next;

    // payload memory
    logic [PAYLOAD_BITS-1:0] pay_mem [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;
    logic                    mem_we;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [SEQ_BITS-1:0]     out_seq_reg,   out_seq_next;
    logic [PAYLOAD_BITS-1:0] out_pay_reg,   out_pay_next;
    logic [STATUS_BITS-1:0]  status_reg,    status_next;
    logic                    last_reg,      last_next;

    // arrival classification
    logic                    seq_zero;
    logic                    restart;
    logic                    rel;
    logic                    newer;
    logic                    in_win;
    logic [SEQ_BITS-1:0]     diff;
    logic [SEQ_BITS-1:0]     rel_exp;
    logic [SLOT_W-1:0]       rel_slot;
    logic                    rel_last;
    logic [SLOT_W:0]         buf_sum;
    logic [SLOT_W-1:0]       buf_slot;
    logic [STATUS_BITS-1:0]  arr_status;

    // tick and scan
    logic [IDLE_BITS-1:0]    idle_inc;
    logic                    flush_go;
    logic [SLOT_W-1:0]       ptr_next_slot;
    logic                    emit_last;
    logic                    out_free;

    assign seq_zero = (seq_reg == '0);
    assign restart  = seq_zero && (exp_reg != '0);
    assign rel      = (seq_reg == exp_reg) || seq_zero;
    assign newer    = (seq_reg > exp_reg);
    assign diff     = seq_reg - exp_reg;
    assign in_win   = (diff < SEQ_BITS'(WINDOW));

    // release moves the expected number one on; a restart releases number zero
    assign rel_exp  = seq_zero ? SEQ_BITS'(1) : exp_reg + 1'b1;
    assign rel_slot = seq_zero ? SLOT_W'(1) : slot_inc(exp_slot_reg, exp_reg);
    assign rel_last = restart || !valid_reg[rel_slot];

    // slot of a future packet, offset from the expected slot
    assign buf_sum  = {1'b0, exp_slot_reg} + {1'b0, diff[SLOT_W-1:0]};
    assign buf_slot = (buf_sum >= (SLOT_W+1)'(WINDOW)) ?
                      SLOT_W'(buf_sum - (SLOT_W+1)'(WINDOW)) : buf_sum[SLOT_W-1:0];

    always_comb
    begin
        if (rel)
        begin
            arr_status = ST_IN_ORDER;
        end
        else if (newer && in_win)
        begin
            arr_status = ST_BUFFERED;
        end
        else if (newer)
        begin
            arr_status = ST_BEYOND;
        end
        else
        begin
            arr_status = ST_STALE;
        end
    end

    // saturating idle count and flush decision
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
    assign flush_go = (idle_inc >= timeout) && (held_reg != '0);

    // scan bookkeeping
    assign ptr_next_slot = slot_inc(ptr_slot_reg, ptr_reg);
    assign emit_last     = cmd.flush ? (held_reg == CNT_W'(1)) : !valid_reg[ptr_next_slot];
    assign out_free      = !out_valid_reg || !out_stall;

    assign mem_we = cmd.arrive && !rel && newer && in_win;

    // status to the controller
    always_comb
    begin
        sts           = '0;
        sts.is_tick   = mode_reg;
        sts.arr_drain = rel && !rel_last;
        sts.flush_go  = flush_go;
        sts.cur_valid = valid_reg[ptr_slot_reg];
        sts.emit_last = emit_last;
        sts.out_free  = out_free;
    end

    // window state update
    always_comb
    begin
        exp_next      = exp_reg;
        exp_slot_next = exp_slot_reg;
        valid_next    = valid_reg;
        held_next     = held_reg;
        idle_next     = idle_reg;
        ptr_next      = ptr_reg;
        ptr_slot_next = ptr_slot_reg;
        if (cmd.arrive)
        begin
            if (rel)
            begin
                if (restart)
                begin
                    valid_next = '0;
                    held_next  = '0;
                end
                exp_next      = rel_exp;
                exp_slot_next = rel_slot;
                ptr_next      = rel_exp;
                ptr_slot_next = rel_slot;
                idle_next     = '0;
            end
            else if (newer && in_win)
            begin
                if (!valid_reg[buf_slot])
                begin
                    held_next = held_reg + 1'b1;
                end
                valid_next[buf_slot] = 1'b1;
                idle_next            = '0;
            end
        end
        if (cmd.tick)
        begin
            if (flush_go)
            begin
                idle_next     = '0;
                ptr_next      = exp_reg + 1'b1;
                ptr_slot_next = slot_inc(exp_slot_reg, exp_reg);
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        if (cmd.skip)
        begin
            ptr_next      = ptr_reg + 1'b1;
            ptr_slot_next = ptr_next_slot;
        end
        if (cmd.emit)
        begin
            valid_next[ptr_slot_reg] = 1'b0;
            held_next                = held_reg - 1'b1;
            exp_next                 = ptr_reg + 1'b1;
            exp_slot_next            = ptr_next_slot;
            ptr_next                 = ptr_reg + 1'b1;
            ptr_slot_next            = ptr_next_slot;
        end
    end

    // output register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_seq_next   = out_seq_reg;
        out_pay_next   = out_pay_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.arrive)
        begin
            out_valid_next = 1'b1;
            out_seq_next   = seq_reg;
            out_pay_next   = pay_reg;
            status_next    = arr_status;
            last_next      = rel ? rel_last : 1'b1;
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_seq_next   = ptr_reg;
            out_pay_next   = rd_data_reg;
            status_next    = cmd.flush ? ST_FLUSHED : ST_IN_ORDER;
            last_next      = emit_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= '0;
            exp_slot_reg  <= '0;
            valid_reg     <= '0;
            held_reg      <= '0;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            exp_reg       <= exp_next;
            exp_slot_reg  <= exp_slot_next;
            valid_reg     <= valid_next;
            held_reg      <= held_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            mode_reg <= mode;
            seq_reg  <= seq_num;
            pay_reg  <= payload_tag;
        end
        ptr_reg      <= ptr_next;
        ptr_slot_reg <= ptr_slot_next;
        out_seq_reg  <= out_seq_next;
        out_pay_reg  <= out_pay_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pay_mem[buf_slot] <= pay_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= pay_mem[ptr_slot_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_seq     = out_seq_reg;
    assign out_payload = out_pay_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

[src/packet_reorder_window.sv]
// packet reorder window: puts numbered packet descriptors back in order
// top level; depends on prw_pkg, prw_regs, prw_ctrl, prw_datapath and the defines header
//
// input channel (in_valid/in_stall): mode 0 is a packet arrival with seq_num and
// payload_tag, mode 1 is one time tick. output channel (out_valid/out_stall)
// carries out_seq, out_payload, status and last; last marks the final result of
// an input transaction. timeout_ticks is written over the apb port at byte 0.
// one transaction is handled at a time: in_stall is high from the cycle after
// acceptance until its work is done. a transaction is captured, then decided;
// the decide step loads an arrival's result into the output register, waiting
// while that register holds a stalled result. each drained or flushed result
// takes a payload memory read, then an output load, and a flush steps the scan
// past each empty slot it passes. a tick without flush gives no result.
// the output register holds one result; while out_stall is high the block
// waits before loading the next one, and a new transaction may be taken while
// the last result still waits. reset empties the window, zeroes the expected
// number and idle count and sets timeout_ticks to 100; no clearing pass.
`include "packet_reorder_window_defines.svh"

module packet_reorder_window
    import prw_pkg::*;
#(
    parameter int WINDOW       = 32,
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // apb configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_BITS-1:0]   paddr,
    input  logic [PDATA_BITS-1:0]   pwdata,
    output logic [PDATA_BITS-1:0]   prdata,
    output logic                    pready,
    // input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic [SEQ_BITS-1:0]     seq_num,
    input  logic [PAYLOAD_BITS-1:0] payload_tag,
    // output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SEQ_BITS-1:0]     out_seq,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic [STATUS_BITS-1:0]  status,
    output logic                    last
);

    logic [TIMEOUT_BITS-1:0] timeout;
    dp_cmd_t                 dp_cmd;
    dp_sts_t                 dp_sts;

    // configuration registers
    prw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timeout (timeout)
    );

    // controller
    prw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // datapath
    prw_datapath #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .timeout     (timeout),
        .mode        (mode),
        .seq_num     (seq_num),
        .payload_tag (payload_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_seq     (out_seq),
        .out_payload (out_payload),
        .status      (status),
        .last        (last)
    );

    // assertions
    `PRW_ASSERT_IMPL(a_load_when_free, dp_cmd.arrive || dp_cmd.emit, dp_sts.out_free,
                     "result loaded over a stalled result")
    `PRW_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(dp_cmd.arrive || dp_cmd.emit),
                     "output valid without a load")
    `PRW_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall,
                     "second transaction taken while busy")
    `PRW_ASSERT_NEXT(a_quiet_tick, dp_cmd.tick && !dp_sts.flush_go,
                     !in_stall && !$rose(out_valid), "tick without flush did not finish")

endmodule

[tb/tb_packet_reorder_window.sv]
// self-checking testbench for packet_reorder_window: directed and random traffic
// against an in-bench reorder predictor, with apb writes of timeout_ticks between phases
// depends on prw_pkg and the packet_reorder_window rtl
module tb_packet_reorder_window;
    import prw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = 32;
    localparam int TAG_BITS     = 16;
    localparam int LIMIT_CYCLES = 500000;
    localparam int QUIET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 80;

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [PADDR_BITS-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    typedef struct packed {
        logic                  mode;
        logic [SEQ_BITS-1:0]   seq;
        logic [TAG_BITS-1:0]   tag;
    } packet_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0]    seq;
        logic [TAG_BITS-1:0]    tag;
        logic [STATUS_BITS-1:0] st;
        logic                   last;
    } release_t;

    // dut ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   mode = 1'b0;
    logic [SEQ_BITS-1:0]    seq_num = '0;
    logic [TAG_BITS-1:0]    payload_tag = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SEQ_BITS-1:0]    out_seq;
    logic [TAG_BITS-1:0]    out_payload;
    logic [STATUS_BITS-1:0] status;
    logic                   last;

    // traffic queues and idling control
    packet_t  arrival_q [$];
    release_t release_fifo [$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       planned_items = 0;
    logic     taken = 1'b0;

    // reorder predictor state
    logic [SEQ_BITS-1:0]     exp_seq = '0;
    logic [WINDOW-1:0]       slot_held = '0;
    logic [TAG_BITS-1:0]     slot_tag [WINDOW];
    int                      held_cnt = 0;
    logic [IDLE_BITS-1:0]    idle_cnt = '0;
    logic [TIMEOUT_BITS-1:0] timeout_cfg = TIMEOUT_RESET;

    // run statistics
    int accepted = 0;
    int checked = 0;
    int mismatches = 0;
    int reg_errors = 0;
    int n_flushed = 0;
    int n_stale = 0;
    int n_beyond = 0;
    int restarts = 0;
    int longest = 0;
    int cycles = 0;

    packet_reorder_window #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (TAG_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .seq_num     (seq_num),
        .payload_tag (payload_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_seq     (out_seq),
        .out_payload (out_payload),
        .status      (status),
        .last        (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic string show(release_t r);
        return $sformatf("seq %h tag %h status %0d last %b", r.seq, r.tag, r.st, r.last);
    endfunction

    function automatic logic [TAG_BITS-1:0] rand_tag();
        return TAG_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    // work out the releases caused by one accepted transaction
    function automatic void reorder_step(packet_t p);
        release_t            res [WINDOW];
        int                  n;
        int                  idx;
        int                  d;
        logic [SEQ_BITS-1:0] base;
        logic [SEQ_BITS-1:0] num;
        n = 0;
        if (p.mode == MODE_ARRIVE)
        begin
            // number zero restarts the count
            if (p.seq == 0 && exp_seq != 0)
            begin
                slot_held = '0;
                held_cnt = 0;
                exp_seq = '0;
                restarts++;
            end
            if (p.seq == exp_seq)
            begin
                // release, then drain the run of buffered successors
                res[n] = {p.seq, p.tag, ST_IN_ORDER, 1'b0};
                n++;
                exp_seq++;
                idx = int'(exp_seq % WINDOW);
                while (held_cnt > 0 && slot_held[idx])
                begin
                    res[n] = {exp_seq, slot_tag[idx], ST_IN_ORDER, 1'b0};
                    n++;
                    slot_held[idx] = 1'b0;
                    held_cnt--;
                    exp_seq++;
                    idx = int'(exp_seq % WINDOW);
                end
                idle_cnt = '0;
            end
            else if (p.seq > exp_seq)
            begin
                if (p.seq - exp_seq < WINDOW)
                begin
                    idx = int'(p.seq % WINDOW);
                    if (!slot_held[idx])
                    begin
                        slot_held[idx] = 1'b1;
                        held_cnt++;
                    end
                    slot_tag[idx] = p.tag;
                    idle_cnt = '0;
                    res[n] = {p.seq, p.tag, ST_BUFFERED, 1'b0};
                end
                else
                begin
                    res[n] = {p.seq, p.tag, ST_BEYOND, 1'b0};
                end
                n++;
            end
            else
            begin
                res[n] = {p.seq, p.tag, ST_STALE, 1'b0};
                n++;
            end
        end
        else
        begin
            // time tick, flush everything held once the timeout is reached
            if (idle_cnt != '1)
                idle_cnt++;
            if (idle_cnt >= timeout_cfg && held_cnt > 0)
            begin
                base = exp_seq;
                for (d = 1; d < WINDOW && held_cnt > 0; d++)
                begin
                    num = base + SEQ_BITS'(d);
                    idx = int'(num % WINDOW);
                    if (slot_held[idx])
                    begin
                        res[n] = {num, slot_tag[idx], ST_FLUSHED, 1'b0};
                        n++;
                        slot_held[idx] = 1'b0;
                        held_cnt--;
                        exp_seq = num + 1'b1;
                    end
                end
                held_cnt = 0;
                idle_cnt = '0;
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (d = 0; d < n; d++)
            release_fifo.push_back(res[d]);
        if (n > longest)
            longest = n;
    endfunction

    // driver: new transaction or idle at the falling edge, random receiver stall
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || taken)
        begin
            if (arrival_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                packet_t p;
                p = arrival_q.pop_front();
                in_valid    <= 1'b1;
                mode        <= p.mode;
                seq_num     <= p.seq;
                payload_tag <= p.tag;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: predict on accepted input, check accepted output
    always @(posedge clk)
    begin
        release_t got;
        release_t want;
        taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            accepted++;
            reorder_step({mode, seq_num, payload_tag});
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_seq, out_payload, status, last};
            checked++;
            case (status)
                ST_FLUSHED: n_flushed++;
                ST_STALE:   n_stale++;
                ST_BEYOND:  n_beyond++;
                default:    ;
            endcase
            if (release_fifo.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: %s", show(got));
                mismatches++;
            end
            else
            begin
                want = release_fifo.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %s, got %s", show(want), show(got));
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic queue_item(logic m, logic [SEQ_BITS-1:0] s, logic [TAG_BITS-1:0] t);
        packet_t p;
        p.mode = m;
        p.seq  = s;
        p.tag  = t;
        arrival_q.push_back(p);
        planned_items++;
    endtask

    task automatic apb_write(logic [PADDR_BITS-1:0] a, logic [PDATA_BITS-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [PADDR_BITS-1:0] a, logic [PDATA_BITS-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $display("register readback: expected %h, got %h", want, prdata);
            reg_errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // set timeout_ticks while the block is idle
    task automatic set_timeout(logic [TIMEOUT_BITS-1:0] t);
        apb_write(TIMEOUT_ADDR, PDATA_BITS'(t));
        timeout_cfg = t;
        apb_check(TIMEOUT_ADDR, PDATA_BITS'(t));
    endtask

    task automatic wait_sent();
        while (arrival_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic wait_quiet();
        wait_sent();
        while (release_fifo.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // one well-formed run of numbers from the expected one, shuffled, with noise
    task automatic plan_burst();
        logic [SEQ_BITS-1:0] base;
        logic [SEQ_BITS-1:0] nums [WINDOW];
        logic [SEQ_BITS-1:0] tmp;
        int                  k;
        int                  j;
        int                  pick;
        int                  r;
        bit                  drop_head;
        base = exp_seq;
        if (base != 0 && $urandom_range(99) < 8)
        begin
            queue_item(MODE_ARRIVE, '0, rand_tag());
            base = 1;
        end
        r = $urandom_range(99);
        if (r < 70)
            k = $urandom_range(6, 1);
        else if (r < 95)
            k = $urandom_range(20, 7);
        else
            k = $urandom_range(WINDOW, WINDOW - 1);
        for (j = 0; j < k; j++)
            nums[j] = base + SEQ_BITS'(j);
        for (j = k - 1; j > 0; j--)
        begin
            pick = $urandom_range(j);
            tmp = nums[j];
            nums[j] = nums[pick];
            nums[pick] = tmp;
        end
        // sometimes hold back the expected number so the whole run drains at once
        if ($urandom_range(99) < 20)
        begin
            for (j = 0; j < k; j++)
                if (nums[j] == base)
                begin
                    nums[j] = nums[k-1];
                    nums[k-1] = base;
                end
        end
        drop_head = (k > 1) && ($urandom_range(99) < 20);
        for (j = 0; j < k; j++)
        begin
            if (!(drop_head && nums[j] == base))
                queue_item(MODE_ARRIVE, nums[j], rand_tag());
            r = $urandom_range(99);
            if (r < 8)
                queue_item(MODE_ARRIVE, nums[$urandom_range(j)], rand_tag());
            else if (r < 13 && base > 1)
                queue_item(MODE_ARRIVE, $urandom_range(base - 1, 1), rand_tag());
            else if (r < 16)
                queue_item(MODE_ARRIVE, base + WINDOW + $urandom_range(4000), rand_tag());
            else if (r < 19)
                queue_item(MODE_ARRIVE, $urandom, rand_tag());
            else if (r < 25)
                queue_item(MODE_TICK, $urandom, rand_tag());
        end
        // a gap stays until the timeout flushes it
        if (drop_head && timeout_cfg <= 16)
            repeat (timeout_cfg) queue_item(MODE_TICK, $urandom, rand_tag());
    endtask

    initial
    begin
        int ph;
        int base_send;
        int base_recv;
        logic [TIMEOUT_BITS-1:0] t;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: release, buffer, duplicate, drain, stale, beyond, flush, restart
        apb_check(TIMEOUT_ADDR, PDATA_BITS'(TIMEOUT_RESET));
        set_timeout(16'd2);
        queue_item(MODE_ARRIVE, 32'd0, 16'h0000);
        queue_item(MODE_ARRIVE, 32'd3, 16'hFFFF);
        queue_item(MODE_ARRIVE, 32'd2, 16'h1234);
        queue_item(MODE_ARRIVE, 32'd2, 16'hAAAA);
        queue_item(MODE_ARRIVE, 32'd1, 16'h5555);
        queue_item(MODE_ARRIVE, 32'd2, 16'h0F0F);
        queue_item(MODE_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(MODE_ARRIVE, 32'd36, 16'h00FF);
        queue_item(MODE_ARRIVE, 32'd35, 16'hFF00);
        queue_item(MODE_ARRIVE, 32'd6, 16'h8001);
        queue_item(MODE_ARRIVE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(MODE_TICK, 32'd0, 16'h0000);
        queue_item(MODE_TICK, 32'd0, 16'h0000);
        queue_item(MODE_ARRIVE, 32'd0, 16'h7FFE);
        queue_item(MODE_ARRIVE, 32'd2, 16'h4242);
        queue_item(MODE_ARRIVE, 32'd0, 16'h1111);
        queue_item(MODE_TICK, 32'd0, 16'h0000);
        queue_item(MODE_TICK, 32'd0, 16'h0000);
        queue_item(MODE_ARRIVE, 32'd1, 16'h2222);
        wait_quiet();

        // zero timeout flushes on the first tick with packets held
        set_timeout(16'd0);
        queue_item(MODE_ARRIVE, 32'd4, 16'h3333);
        queue_item(MODE_TICK, 32'd0, 16'h0000);
        queue_item(MODE_ARRIVE, 32'd5, 16'h4444);

        // random phases with different timeouts and idling
        for (ph = 0; ph < 4; ph++)
        begin
            wait_quiet();
            case (ph)
                0: begin t = 16'd1;     base_send = 0;  base_recv = 0;  end
                1: begin t = 16'd6;     base_send = 66; base_recv = 0;  end
                2: begin t = 16'hFFFF;  base_send = 0;  base_recv = 66; end
                default: begin t = 16'd3; base_send = 21; base_recv = 21; end
            endcase
            set_timeout(t);
            planned_items = 0;
            while (planned_items < PHASE_ITEMS)
            begin
                wait_sent();
                send_idle_pct  = ($urandom_range(3) == 0) ? 0 : base_send;
                recv_stall_pct = ($urandom_range(3) == 0) ? 0 : base_recv;
                plan_burst();
            end
        end
        wait_quiet();
        repeat (40) @(posedge clk);

        if (release_fifo.size() != 0)
            $display("%0d results never arrived", release_fifo.size());
        $display("run: %0d input transactions, %0d restarts, %0d results checked",
                 accepted, restarts, checked);
        $display("run: %0d flushed, %0d stale, %0d beyond window, longest run %0d",
                 n_flushed, n_stale, n_beyond, longest);
        if (mismatches == 0 && reg_errors == 0 && release_fifo.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
